FILE: rtl/aes128_pkg.sv
// aes128_pkg: shared types, constants and byte functions for the AES-128 core.
// Used by aes128_round and aes128_block_encrypt; no dependencies.
package aes128_pkg;

    localparam int NUM_ROUNDS = 10;
    localparam int ROUND_W    = $clog2(NUM_ROUNDS + 1);

    localparam logic [7:0] RCON_INIT = 8'h01;
    localparam logic [7:0] POLY_LOW  = 8'h1B;

    localparam logic CFG_KEY_HI = 1'b0;
    localparam logic CFG_KEY_LO = 1'b1;

    typedef struct packed {
        logic [63:0] plaintext_hi;
        logic [63:0] plaintext_lo;
    } t_aes_in;

    typedef struct packed {
        logic [63:0] ciphertext_hi;
        logic [63:0] ciphertext_lo;
    } t_aes_out;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,
        8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
        8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,
        8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
        8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,
        8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
        8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,
        8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
        8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,
        8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
        8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,
        8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
        8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,
        8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
        8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,
        8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
        8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,
        8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
        8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,
        8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
        8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,
        8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
        8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,
        8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
        8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,
        8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
        8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,
        8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
        8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,
        8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
        8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,
        8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
    };

    function automatic logic [7:0] sbox(input logic [7:0] b);
        return SBOX[b];
    endfunction

    // multiply by x in GF(2^8)
    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? POLY_LOW : 8'h00);
    endfunction

endpackage

FILE: rtl/aes128_round.sv
// aes128_round: one AES round (SubBytes, ShiftRows, optional MixColumns,
// AddRoundKey) plus the matching on-the-fly key expansion step. Uses aes128_pkg.
module aes128_round
    import aes128_pkg::*;
(
    input  logic [127:0] i_state,
    input  logic [127:0] i_key,
    input  logic [7:0]   i_rcon,
    input  logic         i_last,
    output logic [127:0] o_state,
    output logic [127:0] o_key
);

    logic [7:0] st [16];
    logic [7:0] rk [16];
    logic [7:0] sh [16];
    logic [7:0] mx [16];
    logic [7:0] nk [16];

    always_comb begin
        for (int n = 0; n < 16; n++) begin
            st[n] = i_state[127 - 8*n -: 8];
            rk[n] = i_key[127 - 8*n -: 8];
        end
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                sh[4*c + r] = sbox(st[4*((c + r) % 4) + r]);
            end
        end
        for (int c = 0; c < 4; c++) begin
            logic [7:0] a, b, cc, d, all;
            a   = sh[4*c];
            b   = sh[4*c + 1];
            cc  = sh[4*c + 2];
            d   = sh[4*c + 3];
            all = a ^ b ^ cc ^ d;
            if (i_last) begin
                mx[4*c]     = a;
                mx[4*c + 1] = b;
                mx[4*c + 2] = cc;
                mx[4*c + 3] = d;
            end else begin
                mx[4*c]     = a  ^ all ^ xtime(a ^ b);
                mx[4*c + 1] = b  ^ all ^ xtime(b ^ cc);
                mx[4*c + 2] = cc ^ all ^ xtime(cc ^ d);
                mx[4*c + 3] = d  ^ all ^ xtime(d ^ a);
            end
        end
        nk[0] = rk[0] ^ sbox(rk[13]) ^ i_rcon;
        nk[1] = rk[1] ^ sbox(rk[14]);
        nk[2] = rk[2] ^ sbox(rk[15]);
        nk[3] = rk[3] ^ sbox(rk[12]);
        for (int n = 4; n < 16; n++) begin
            nk[n] = rk[n] ^ nk[n - 4];
        end
        for (int n = 0; n < 16; n++) begin
            o_state[127 - 8*n -: 8] = mx[n] ^ nk[n];
            o_key[127 - 8*n -: 8]   = nk[n];
        end
    end

endmodule

FILE: rtl/aes128_block_encrypt.sv
// aes128_block_encrypt: iterative AES-128 encryption core, one round per cycle.
// Steps: the key addition is registered at the edge that takes a request, then the ten
// rounds of aes128_round are registered in turn; o_done rises with the last round.
// A new request is not taken while busy is high, from that edge until the last round.
// Reset (i_rst_n low, synchronous) clears the sequencer and both key registers.
// The result is shown for one cycle with o_done; the receiver cannot stall.
module aes128_block_encrypt
    import aes128_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_aes_in     i_plaintext,
    output logic        o_done,
    output t_aes_out    o_ciphertext,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [63:0] i_cfg_data
);

    logic [63:0]        r_key_hi;
    logic [63:0]        r_key_lo;
    logic [127:0]       r_state;
    logic [127:0]       r_rkey;
    logic [7:0]         r_rcon;
    logic [ROUND_W-1:0] r_round;
    logic               r_busy;
    logic               r_done;

    logic [127:0]       n_state;
    logic [127:0]       n_rkey;
    logic               last;
    logic               accept;

    assign accept = start && !r_busy;
    assign last   = (r_round == ROUND_W'(NUM_ROUNDS));

    aes128_round u_round (
        .i_state (r_state),
        .i_key   (r_rkey),
        .i_rcon  (r_rcon),
        .i_last  (last),
        .o_state (n_state),
        .o_key   (n_rkey)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_hi <= '0;
            r_key_lo <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KEY_HI: r_key_hi <= i_cfg_data;
                CFG_KEY_LO: r_key_lo <= i_cfg_data;
                default:    r_key_hi <= r_key_hi;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_round <= '0;
        end else begin
            r_done <= 1'b0;
            if (accept) begin
                r_busy  <= 1'b1;
                r_round <= ROUND_W'(1);
            end else if (r_busy) begin
                if (last) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_round <= r_round + ROUND_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_state <= {i_plaintext.plaintext_hi, i_plaintext.plaintext_lo}
                     ^ {r_key_hi, r_key_lo};
            r_rkey  <= {r_key_hi, r_key_lo};
            r_rcon  <= RCON_INIT;
        end else if (r_busy) begin
            r_state <= n_state;
            r_rkey  <= n_rkey;
            r_rcon  <= xtime(r_rcon);
        end
    end

    assign busy                       = r_busy;
    assign o_done                     = r_done;
    assign o_ciphertext.ciphertext_hi = r_state[127:64];
    assign o_ciphertext.ciphertext_lo = r_state[63:0];

`ifndef SYNTH
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_busy && r_round == ROUND_W'(1))
        else $error("request not taken into round one");

    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy) && $past(last))
        else $error("done without final round");

    a_round_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_round >= ROUND_W'(1) && r_round <= ROUND_W'(NUM_ROUNDS))
        else $error("round count out of range");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("done while busy");
`endif

endmodule

FILE: tb/aes128_block_encrypt_checker.sv
`timescale 1ns / 100ps
// aes128_block_encrypt_checker: watches requests, results and key writes of the AES-128 core.
// Predicts each ciphertext with a local AES-128 model and compares results in order.
// Depends on aes128_pkg for the payload types and the key register indexes.
module aes128_block_encrypt_checker
    import aes128_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  t_aes_in     i_plaintext,
    input  logic        i_done,
    input  t_aes_out    i_ciphertext,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [63:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int         MAX_REPORTS = 10;
    localparam int         ROUNDS      = 10;
    localparam logic [7:0] RCON_FIRST  = 8'h01;
    localparam logic [7:0] AFFINE_C    = 8'h63;
    localparam logic [7:0] REDUCE      = 8'h1B;

    logic [7:0]  subst [256];
    logic [63:0] key_hi = '0;
    logic [63:0] key_lo = '0;
    t_aes_out    ciphertext_q [$];

    function automatic logic [7:0] gf_twice(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? REDUCE : 8'h00);
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        logic [7:0] p;
        acc = '0;
        p   = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) acc ^= p;
            p = gf_twice(p);
        end
        return acc;
    endfunction

    // S-box from the field inverse and the affine map
    initial begin : build_subst
        logic [7:0] inv;
        for (int n = 0; n < 256; n++) begin
            inv = 8'h00;
            for (int m = 1; m < 256; m++)
                if (gf_mul(n[7:0], m[7:0]) == 8'h01) inv = m[7:0];
            subst[n] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                     ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ AFFINE_C;
        end
    end

    // byte n of a 128-bit value sits at bits 127-8n down; byte n is row n%4, column n/4
    function automatic t_aes_out encrypt_block(input t_aes_in blk, input logic [63:0] k_hi,
                                               input logic [63:0] k_lo);
        logic [127:0] data;
        logic [127:0] key;
        logic [7:0]   st [16];
        logic [7:0]   rk [16];
        logic [7:0]   tmp [16];
        logic [7:0]   a, b, c, d, all;
        logic [7:0]   rcon;
        t_aes_out     res;
        data = blk;
        key  = {k_hi, k_lo};
        rcon = RCON_FIRST;
        for (int n = 0; n < 16; n++) begin
            rk[n] = key[127 - 8*n -: 8];
            st[n] = data[127 - 8*n -: 8] ^ rk[n];
        end
        for (int r = 1; r <= ROUNDS; r++) begin
            for (int col = 0; col < 4; col++)
                for (int row = 0; row < 4; row++)
                    tmp[4*col + row] = subst[st[4*((col + row) % 4) + row]];
            if (r < ROUNDS) begin
                for (int col = 0; col < 4; col++) begin
                    a   = tmp[4*col];
                    b   = tmp[4*col + 1];
                    c   = tmp[4*col + 2];
                    d   = tmp[4*col + 3];
                    all = a ^ b ^ c ^ d;
                    tmp[4*col]     = a ^ all ^ gf_twice(a ^ b);
                    tmp[4*col + 1] = b ^ all ^ gf_twice(b ^ c);
                    tmp[4*col + 2] = c ^ all ^ gf_twice(c ^ d);
                    tmp[4*col + 3] = d ^ all ^ gf_twice(d ^ a);
                end
            end
            rk[0] = rk[0] ^ subst[rk[13]] ^ rcon;
            rk[1] = rk[1] ^ subst[rk[14]];
            rk[2] = rk[2] ^ subst[rk[15]];
            rk[3] = rk[3] ^ subst[rk[12]];
            for (int n = 4; n < 16; n++)
                rk[n] = rk[n] ^ rk[n - 4];
            rcon = gf_twice(rcon);
            for (int n = 0; n < 16; n++)
                st[n] = tmp[n] ^ rk[n];
        end
        for (int n = 0; n < 16; n++)
            data[127 - 8*n -: 8] = st[n];
        res = data;
        return res;
    endfunction

    task automatic note_failure(input string msg);
        o_fail_count++;
        if (o_fail_count <= MAX_REPORTS) $display("%0t: %s", $time, msg);
    endtask

    always @(posedge i_clk) begin : monitor
        t_aes_out want;
        if (!i_rst_n) begin
            key_hi = '0;
            key_lo = '0;
        end else begin
            if (i_done !== 1'b0) begin
                if (ciphertext_q.size() == 0) begin
                    note_failure($sformatf("result with no request outstanding: %h_%h",
                                           i_ciphertext.ciphertext_hi,
                                           i_ciphertext.ciphertext_lo));
                end else begin
                    want = ciphertext_q.pop_front();
                    if (i_ciphertext.ciphertext_hi !== want.ciphertext_hi ||
                        i_ciphertext.ciphertext_lo !== want.ciphertext_lo) begin
                        note_failure($sformatf("ciphertext mismatch: hi exp %h got %h, lo exp %h got %h",
                                               want.ciphertext_hi, i_ciphertext.ciphertext_hi,
                                               want.ciphertext_lo, i_ciphertext.ciphertext_lo));
                    end
                end
            end
            if (i_start === 1'b1 && i_busy === 1'b0)
                ciphertext_q.push_back(encrypt_block(i_plaintext, key_hi, key_lo));
            if (i_cfg_we === 1'b1) begin
                case (i_cfg_idx)
                    CFG_KEY_HI: key_hi = i_cfg_data;
                    CFG_KEY_LO: key_lo = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending = ciphertext_q.size();
    end

endmodule

FILE: tb/aes128_block_encrypt_tb.sv
`timescale 1ns / 100ps
// aes128_block_encrypt_tb: stimulus and verdict for the AES-128 encryption core.
// Directed and random requests under several keys; checking is in aes128_block_encrypt_checker.
// Depends on aes128_pkg, the RTL and the checker module.
module aes128_block_encrypt_tb;
    import aes128_pkg::*;

    localparam longint RUN_LIMIT_NS    = 64'd10_000_000;
    localparam int     RAND_PHASES     = 12;
    localparam int     ITEMS_PER_PHASE = 150;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_aes_in     i_plaintext = '0;
    logic        o_done;
    t_aes_out    o_ciphertext;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = CFG_KEY_HI;
    logic [63:0] i_cfg_data = '0;
    int          fail_count;
    int          pending;

    always #6 i_clk = ~i_clk;

    aes128_block_encrypt DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_plaintext  (i_plaintext),
        .o_done       (o_done),
        .o_ciphertext (o_ciphertext),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    aes128_block_encrypt_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_plaintext  (i_plaintext),
        .i_done       (o_done),
        .i_ciphertext (o_ciphertext),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // start stays high across back-to-back requests; a gap counts idle cycles after busy drops
    task automatic send_block(input t_aes_in blk, input int gap);
        start       <= 1'b1;
        i_plaintext <= blk;
        do @(posedge i_clk); while (busy !== 1'b0);
        if (gap > 0) begin
            start <= 1'b0;
            do @(posedge i_clk); while (busy !== 1'b0);
            repeat (gap - 1) @(posedge i_clk);
        end
    endtask

    task automatic wait_all_results();
        start <= 1'b0;
        do @(negedge i_clk); while (pending != 0 || busy !== 1'b0);
        @(posedge i_clk);
    endtask

    task automatic load_key(input bit write_hi, input bit write_lo,
                            input logic [63:0] hi, input logic [63:0] lo);
        if (write_hi) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CFG_KEY_HI;
            i_cfg_data <= hi;
            @(posedge i_clk);
        end
        if (write_lo) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CFG_KEY_LO;
            i_cfg_data <= lo;
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
    endtask

    function automatic int pick_gap(input bit steady);
        int r;
        if (steady) return 0;
        r = $urandom_range(99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(3, 1);
        if (r < 95) return $urandom_range(10, 4);
        return $urandom_range(80, 20);
    endfunction

    function automatic t_aes_in random_block();
        t_aes_in blk;
        int      kind;
        kind = $urandom_range(19);
        blk  = {$urandom, $urandom, $urandom, $urandom};
        if (kind == 0) blk = '0;
        else if (kind == 1) blk = '1;
        else if (kind == 2) blk = 128'd1 << $urandom_range(127);
        return blk;
    endfunction

    initial begin
        #(RUN_LIMIT_NS);
        $display("aes128_block_encrypt_tb: FAIL");
        $finish;
    end

    initial begin
        int sel;
        bit steady;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // key left at reset value
        send_block('0, 0);
        send_block('1, 0);
        send_block({64'h8000_0000_0000_0000, 64'h0}, 3);
        send_block({64'h0, 64'h1}, 0);
        send_block({64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA}, 1);
        wait_all_results();

        load_key(1'b1, 1'b1, 64'h0001_0203_0405_0607, 64'h0809_0A0B_0C0D_0E0F);
        send_block({64'h0011_2233_4455_6677, 64'h8899_AABB_CCDD_EEFF}, 0);
        send_block('0, 0);
        send_block('1, 5);
        wait_all_results();

        load_key(1'b1, 1'b1, '1, '1);
        send_block('0, 2);
        send_block('1, 0);
        send_block({64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210}, 0);
        wait_all_results();

        load_key(1'b1, 1'b1, 64'h2B7E_1516_28AE_D2A6, 64'hABF7_1588_09CF_4F3C);
        send_block({64'h3243_F6A8_885A_308D, 64'h3131_98A2_E037_0734}, 0);
        wait_all_results();

        // one half of the key only
        load_key(1'b1, 1'b0, '0, '0);
        send_block('1, 0);
        send_block(random_block(), 0);
        wait_all_results();
        load_key(1'b0, 1'b1, '0, '1);
        send_block('0, 4);
        send_block(random_block(), 0);

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            wait_all_results();
            case (ph)
                0: load_key(1'b1, 1'b1, '1, '1);
                1: load_key(1'b1, 1'b1, '0, '0);
                2: load_key(1'b1, 1'b1, '0, '1);
                default: begin
                    sel = $urandom_range(5);
                    load_key(sel != 1, sel != 2, {$urandom, $urandom}, {$urandom, $urandom});
                end
            endcase
            steady = 1'b0;
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                if ($urandom_range(49) == 0) steady = !steady;
                send_block(random_block(), pick_gap(steady));
                if ($urandom_range(199) == 0) wait_all_results();
            end
        end

        wait_all_results();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("aes128_block_encrypt_tb: PASS");
        end else begin
            $display("aes128_block_encrypt_tb: FAIL");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/aes128_pkg.sv
rtl/aes128_round.sv
rtl/aes128_block_encrypt.sv
tb/aes128_block_encrypt_checker.sv
tb/aes128_block_encrypt_tb.sv
